// ----- hdl/tdt_pkg.sv -----
// Shared types, constants and helper functions of the template delimiter tokenizer.
// No dependencies; imported by every module of the block.
package tdt_pkg;

	typedef enum logic [1:0] {
		MODE_TEXT    = 2'd0,
		MODE_SCRIPT  = 2'd1,
		MODE_ECHO    = 2'd2,
		MODE_COMMENT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TEXT       = 3'd0,
		KIND_SCRIPT     = 3'd1,
		KIND_ECHO       = 3'd2,
		KIND_SCRIPT_END = 3'd3,
		KIND_ECHO_END   = 3'd4,
		KIND_TMPL_END   = 3'd5
	} kind_t;

	localparam logic [7:0] CH_OPEN   = 8'h7B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_CLOSE  = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// scan state: pending flag above the mode
	typedef struct packed {
		logic  pend;
		mode_t mode;
	} scan_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [1:0]    cnt;
		result_t [2:0] res;
	} bundle_t;

	function automatic logic [7:0] trig_of(mode_t m);
		logic [7:0] t;
		t = CH_OPEN;
		unique case (m)
			MODE_TEXT:    t = CH_OPEN;
			MODE_SCRIPT:  t = CH_CLOSE;
			MODE_ECHO:    t = CH_EQ;
			MODE_COMMENT: t = CH_HASH;
			default:      t = CH_OPEN;
		endcase
		return t;
	endfunction

	function automatic bundle_t push(bundle_t b, kind_t k, logic [7:0] d, logic l);
		bundle_t r;
		r = b;
		r.res[b.cnt].kind = k;
		r.res[b.cnt].data = d;
		r.res[b.cnt].last = l;
		r.cnt = b.cnt + 2'd1;
		return r;
	endfunction

	// plain byte of the given mode; comment bytes are dropped
	function automatic bundle_t push_plain(bundle_t b, mode_t m, logic [7:0] d);
		bundle_t r;
		r = b;
		unique case (m)
			MODE_TEXT:    r = push(b, KIND_TEXT, d, 1'b0);
			MODE_SCRIPT:  r = push(b, KIND_SCRIPT, d, 1'b0);
			MODE_ECHO:    r = push(b, KIND_ECHO, d, 1'b0);
			MODE_COMMENT: r = b;
			default:      r = b;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/tdt_front.sv -----
// Front end: accepts template bytes, tracks the scan state and builds result bundles.
// Depends on tdt_pkg.
module tdt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_byte,
	input  logic            end_of_template,
	input  logic            q_full,
	output logic            q_wr,
	output tdt_pkg::bundle_t q_wdata
);
	import tdt_pkg::*;

	scan_t   scan_q;
	scan_t   scan_nx;
	bundle_t b;
	logic    accept;
	logic [7:0] trig;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign trig     = trig_of(scan_q.mode);

	always_comb begin
		b       = '0;
		scan_nx = scan_q;
		if (!scan_q.pend) begin
			if (in_byte == trig) begin
				scan_nx.pend = 1'b1;
			end else begin
				b = push_plain(b, scan_q.mode, in_byte);
			end
		end else if (in_byte == CH_BSLASH) begin
			b = push_plain(b, scan_q.mode, trig);
			scan_nx.pend = 1'b0;
		end else if (scan_q.mode == MODE_TEXT &&
			(in_byte == CH_OPEN || in_byte == CH_EQ || in_byte == CH_HASH)) begin
			scan_nx.pend = 1'b0;
			priority if (in_byte == CH_OPEN) begin
				scan_nx.mode = MODE_SCRIPT;
			end else if (in_byte == CH_EQ) begin
				scan_nx.mode = MODE_ECHO;
			end else begin
				scan_nx.mode = MODE_COMMENT;
			end
		end else if (scan_q.mode != MODE_TEXT && in_byte == CH_CLOSE) begin
			if (scan_q.mode == MODE_SCRIPT) begin
				b = push(b, KIND_SCRIPT_END, 8'h00, 1'b0);
			end else if (scan_q.mode == MODE_ECHO) begin
				b = push(b, KIND_ECHO_END, 8'h00, 1'b0);
			end
			scan_nx = '{pend: 1'b0, mode: MODE_TEXT};
		end else begin
			// flush the pending byte, then rescan the new one
			b = push_plain(b, scan_q.mode, trig);
			if (in_byte == trig) begin
				scan_nx.pend = 1'b1;
			end else begin
				scan_nx.pend = 1'b0;
				b = push_plain(b, scan_q.mode, in_byte);
			end
		end

		if (end_of_template) begin
			if (scan_nx.pend) begin
				b = push_plain(b, scan_nx.mode, trig_of(scan_nx.mode));
			end
			b       = push(b, KIND_TMPL_END, 8'h00, 1'b1);
			scan_nx = '{pend: 1'b0, mode: MODE_TEXT};
		end
	end

	// drop empty bundles here so the back end only sees real results
	assign q_wr    = accept && (b.cnt != 2'd0);
	assign q_wdata = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '{pend: 1'b0, mode: MODE_TEXT};
		end else if (accept) begin
			scan_q <= scan_nx;
		end
	end

endmodule

// ----- hdl/tdt_queue.sv -----
// Short bundle queue between the front and back ends.
// Depends on tdt_pkg.
module tdt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  tdt_pkg::bundle_t wdata,
	output logic             full,
	input  logic             rd,
	output tdt_pkg::bundle_t rdata,
	output logic             empty
);
	import tdt_pkg::*;

	bundle_t          mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q;
	logic [QAW-1:0]   rptr_q;
	logic [QAW:0]     count_q;

	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/tdt_back.sv -----
// Back end: unpacks queued bundles into single results behind an output register.
// Depends on tdt_pkg.
module tdt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  tdt_pkg::bundle_t q_rdata,
	output logic             q_rd,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       kind,
	output logic [7:0]       out_byte,
	output logic             last
);
	import tdt_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	result_t    res_q;
	logic       load;
	logic       at_end;

	assign load   = !q_empty && (!valid_q || !out_stall);
	assign at_end = (idx_q == q_rdata.cnt - 2'd1);
	assign q_rd   = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= q_rdata.res[idx_q];
		end
	end

	assign out_valid = valid_q;
	assign kind      = res_q.kind;
	assign out_byte  = res_q.data;
	assign last      = res_q.last;

endmodule

// ----- hdl/template_delimiter_tokenizer_unit.sv -----
// Template delimiter tokenizer: splits template text into text, script and echo bytes
// and block markers. Depends on tdt_pkg, tdt_front, tdt_queue and tdt_back.
//
// Input channel: in_valid/in_stall carry one template byte (in_byte) and the
// end_of_template flag; a byte is taken at an edge where in_valid is high and
// in_stall low. One byte can be taken every cycle while in_stall stays low.
// Output channel: out_valid/out_stall carry one result (kind, out_byte, last);
// last marks the template end result, after which scanning restarts in text mode.
// A byte gives zero to three results. The results of a byte pass through the bundle
// queue and then the output register; results leave at one per cycle while out_stall
// is low, so the sustained input rate is one byte per cycle while each byte yields at
// most one result, and otherwise set by the single output register.
// A four-entry bundle queue separates the two sides: when the receiver stalls,
// the output register holds its result and input bytes keep flowing until the
// queue fills, then in_stall rises.
// Reset clears the scan state to text mode with nothing pending and empties the
// queue and output register.
module template_delimiter_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_template,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] out_byte,
	output logic       last
);
	import tdt_pkg::*;

	bundle_t q_wdata;
	bundle_t q_rdata;
	logic    q_wr;
	logic    q_rd;
	logic    q_full;
	logic    q_empty;

	tdt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.end_of_template (end_of_template),
		.q_full          (q_full),
		.q_wr            (q_wr),
		.q_wdata         (q_wdata)
	);

	tdt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
